// ===== rtl/expiring_key_table_defines.svh =====
// Assertion macros shared by the expiring key table RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef EXPIRING_KEY_TABLE_DEFINES_SVH
`define EXPIRING_KEY_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define EKT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that post holds in the cycle after pre.
`define EKT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);
`else
`define EKT_ASSERT(lbl, clk, rst_n, prop, msg)
`define EKT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/ekt_pkg.sv =====
// Package for the expiring key table: sizes, mode codes, register indexes, types.
// No dependencies.
package ekt_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_W      = 48;
    localparam int TIME_W     = 32;
    localparam int HOLD_W     = 24;
    localparam int COLOR_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_TRACK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD    = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLOR   = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OPACITY = 8'd3;

    localparam logic [HOLD_W-1:0]  HOLD_RESET    = 24'd1000;
    localparam logic [COLOR_W-1:0] COLOR_RESET   = 24'hFFFFFF;
    localparam logic [BYTE_W-1:0]  OPACITY_RESET = 8'hFF;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

// ===== rtl/expiring_key_table.sv =====
// Expiring key table: round-robin keyed table with per-entry expiry times.
// Depends on ekt_pkg and expiring_key_table_defines.svh.
//
//  Channel   | Direction | Handshake               | Contents
//  ----------+-----------+-------------------------+--------------------------------
//  s (input) | in        | i_s_tvalid / o_s_tready | tuser: mode; tdata: key, now_time
//  m (output)| out       | o_m_tvalid / i_m_tready | tdata: result flags and bytes
//  cfg       | in        | i_cfg_we (no ready)     | register index and write data
//
// Each word walks the slots in turn, a store read (S_READ) then a compare (S_CMP) per slot,
// and then loads the output register in S_DONE; a new word is taken only back in S_IDLE,
// so words do not overlap. Track and query words that are gated off or hit early finish
// without a full scan. The key and expiry compares are the shared unit. Reset is synchronous
// and clears every valid bit at once, so no clearing pass is needed. A stalled output holds
// its word; the next result waits until it frees up.
`include "expiring_key_table_defines.svh"

module expiring_key_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: key [47:0], now_time [79:48]
    input  logic [ekt_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: mode [1:0]
    input  logic [ekt_pkg::MODE_W-1:0]        i_s_tuser,
    // Output stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: found_live [0], red [8:1], green [16:9], blue [24:17], alpha [32:25],
    //        any_live [33], zero [39:34]
    output logic [ekt_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [ekt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ekt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    import ekt_pkg::*;

    // Configuration registers.
    logic               r_enable;
    logic [HOLD_W-1:0]  r_hold;
    logic [COLOR_W-1:0] r_color;
    logic [BYTE_W-1:0]  r_opacity;

    // Entry store. A slot is occupied when its valid bit is set; an empty slot
    // is never matched, since a hit needs the valid bit.
    logic [KEY_W-1:0]   r_key_mem [SLOTS];
    logic [TIME_W-1:0]  r_exp_mem [SLOTS];
    logic [SLOTS-1:0]   r_valid, n_valid;
    logic [KEY_W-1:0]   r_rd_key;
    logic [TIME_W-1:0]  r_rd_exp;

    // Sequencer and working registers for the word in flight.
    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0]  r_next_slot, n_next_slot;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [TIME_W-1:0]  r_exp_new, n_exp_new;
    logic               r_found, n_found;
    logic               r_live, n_live;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // Store write port, driven by the compare step of a track word.
    logic               key_we;
    logic               exp_we;
    logic [SLOT_W-1:0]  wr_addr;

    logic               s_accept;
    logic               hit;
    logic               live;
    logic               last_slot;
    logic [TIME_W:0]    exp_sum;
    logic [KEY_W-1:0]   in_key;
    logic [TIME_W-1:0]  in_now;

    assign in_key     = i_s_tdata[KEY_W-1:0];
    assign in_now     = i_s_tdata[KEY_W+TIME_W-1:KEY_W];
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // New expiry for a track word saturates at the top of the time range.
    assign exp_sum = {1'b0, in_now} + {{(TIME_W + 1 - HOLD_W){1'b0}}, r_hold};

    // Shared compare unit, fed from the registered store read.
    assign hit       = r_valid[r_idx] && (r_rd_key == r_key);
    assign live      = (r_rd_exp > r_now);
    assign last_slot = (r_idx == SLOT_W'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_hold    <= HOLD_RESET;
            r_color   <= COLOR_RESET;
            r_opacity <= OPACITY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ENABLE:  r_enable  <= i_cfg_wdata[0];
                CFG_HOLD:    r_hold    <= i_cfg_wdata[HOLD_W-1:0];
                CFG_COLOR:   r_color   <= i_cfg_wdata[COLOR_W-1:0];
                CFG_OPACITY: r_opacity <= i_cfg_wdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_next_slot = r_next_slot;
        n_mode      = r_mode;
        n_key       = r_key;
        n_now       = r_now;
        n_exp_new   = r_exp_new;
        n_found     = r_found;
        n_live      = r_live;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        key_we      = 1'b0;
        exp_we      = 1'b0;
        wr_addr     = r_idx;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_mode    = i_s_tuser;
                    n_key     = in_key;
                    n_now     = in_now;
                    n_exp_new = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_live    = 1'b0;
                    // Track and query skip the scan when disabled or for key zero; the unused
                    // mode code skips it too. Each still returns a result word.
                    if (i_s_tuser inside {MODE_TRACK, MODE_QUERY}) begin
                        n_state = (r_enable && (in_key != '0)) ? S_READ : S_DONE;
                    end else if (i_s_tuser == MODE_TICK) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = last_slot ? S_DONE : S_READ;
                n_idx   = last_slot ? r_idx : r_idx + SLOT_W'(1);
                case (r_mode)
                    MODE_TRACK: begin
                        if (hit) begin
                            // Refresh in place, even when the entry has expired.
                            exp_we  = 1'b1;
                            n_state = S_DONE;
                        end else if (last_slot) begin
                            // No entry holds the key: replace the round-robin slot.
                            key_we               = 1'b1;
                            exp_we               = 1'b1;
                            wr_addr              = r_next_slot;
                            n_valid[r_next_slot] = 1'b1;
                            n_next_slot = (r_next_slot == SLOT_W'(SLOTS - 1)) ?
                                          '0 : r_next_slot + SLOT_W'(1);
                        end
                    end
                    MODE_QUERY: begin
                        if (hit && live) begin
                            n_found = 1'b1;
                            n_state = S_DONE;
                        end
                    end
                    MODE_TICK: begin
                        if (r_valid[r_idx]) begin
                            if (live) begin
                                n_live = 1'b1;
                            end else begin
                                n_valid[r_idx] = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {
                        {(OUT_DATA_W - 34){1'b0}},
                        r_live,
                        r_found ? r_opacity     : {BYTE_W{1'b0}},
                        r_found ? r_color[7:0]  : {BYTE_W{1'b0}},
                        r_found ? r_color[15:8] : {BYTE_W{1'b0}},
                        r_found ? r_color[23:16] : {BYTE_W{1'b0}},
                        r_found
                    };
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_next_slot <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_live      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_next_slot <= n_next_slot;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_live      <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_now      <= n_now;
        r_exp_new  <= n_exp_new;
        r_out_data <= n_out_data;
    end

    // Entry store: one write port, one registered read port at the scan index.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[wr_addr] <= r_key;
        end
        if (exp_we) begin
            r_exp_mem[wr_addr] <= r_exp_new;
        end
        r_rd_key <= r_key_mem[r_idx];
        r_rd_exp <= r_exp_mem[r_idx];
    end

    `EKT_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, s_accept,
        r_state != S_IDLE, "accepted word did not start the sequencer")
    `EKT_ASSERT(a_found_and_live_exclusive, i_clk, i_rst_n,
        !(r_out_valid && r_out_data[0] && r_out_data[33]), "query and tick flags both set")
    `EKT_ASSERT(a_bytes_only_when_found, i_clk, i_rst_n,
        !(r_out_valid && !r_out_data[0] && (r_out_data[32:1] != '0)), "color bytes without a hit")
    `EKT_ASSERT_NEXT(a_stalled_result_waits, i_clk, i_rst_n,
        (r_state == S_DONE) && r_out_valid && !i_m_tready, r_state == S_DONE,
        "result overwrote a stalled word")

endmodule
